### hdl/text_console_cursor_writer_unit_assert.svh
// Assertion macros for the text console cursor writer.
// Included by the top level; needs nothing else.
`ifndef TEXT_CONSOLE_CURSOR_WRITER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_WRITER_UNIT_ASSERT_SVH

// Check that a condition holds in the same cycle as its trigger
`define TCCW_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition holds in the cycle after its trigger
`define TCCW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/tccw_pkg.sv
// Shared constants, codes and types of the text console cursor writer.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tccw_pkg;

   // Screen geometry
   localparam int SCREEN_COLUMNS = 80;
   localparam int SCREEN_ROWS    = 25;
   localparam int TAB_STOP       = 8;
   localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Field widths
   localparam int COL_W       = 7;
   localparam int ROW_W       = 5;
   localparam int CELL_W      = 11;
   localparam int CHAR_W      = 8;
   localparam int ATTR_W      = 8;
   localparam int CELL_WORD_W = CHAR_W + ATTR_W;
   localparam int REQ_W       = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 32;

   // Request codes
   localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
   localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
   localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

   // Control characters
   localparam logic [CHAR_W-1:0] CODE_TAB = 8'd9;
   localparam logic [CHAR_W-1:0] CODE_LF  = 8'd10;
   localparam logic [CHAR_W-1:0] CODE_CR  = 8'd13;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_CHAR_ATTR  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLANK_ATTR = 1'd1;

   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;

   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_ROWS - 1);
   localparam logic [COL_W-1:0] LAST_COL = COL_W'(SCREEN_COLUMNS - 1);

   // Classified command
   typedef enum logic [2:0] {
      CMD_PRINT,
      CMD_LF,
      CMD_CR,
      CMD_TAB,
      CMD_CLEAR,
      CMD_READ,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [CHAR_W-1:0]   code;
      logic [CELL_W-1:0]   cell_addr;
      logic                in_range;
   } cmd_type;

   // Back-end status seen by the front and the top level
   typedef struct packed {
      logic init_busy;
      logic sweep_busy;
   } back_status_type;

endpackage

`default_nettype wire

### hdl/tccw_front.sv
// Front end: accepts request words and classifies them into commands.
// Depends on tccw_pkg; feeds tccw_queue.
`timescale 1ns / 1ps
`default_nettype none

module tccw_front
   import tccw_pkg::*;
(
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,   // char_code[7:0], cell_index[18:8]
   input  wire logic [REQ_W-1:0]       req_tuser,   // req_type[1:0]
   input  wire back_status_type        status,
   output logic                        push_valid,
   input  wire logic                   push_ready,
   output cmd_type                     push_cmd
);

   // Hold off requests during the power-up clearing pass
   assign push_valid = req_tvalid && !status.init_busy;
   assign req_tready = push_ready && !status.init_busy;

   // Decode request type and control characters
   always_comb begin
      push_cmd.code      = req_tdata[CHAR_W-1:0];
      push_cmd.cell_addr = req_tdata[CHAR_W +: CELL_W];
      push_cmd.in_range  = req_tdata[CHAR_W +: CELL_W] < CELL_W'(CELL_COUNT);
      case (req_tuser)
         REQ_PUT: begin
            case (req_tdata[CHAR_W-1:0])
               CODE_LF:  push_cmd.kind = CMD_LF;
               CODE_CR:  push_cmd.kind = CMD_CR;
               CODE_TAB: push_cmd.kind = CMD_TAB;
               default:  push_cmd.kind = CMD_PRINT;
            endcase
         end
         REQ_CLEAR: push_cmd.kind = CMD_CLEAR;
         REQ_READ:  push_cmd.kind = CMD_READ;
         default:   push_cmd.kind = CMD_NOP;
      endcase
   end

endmodule

`default_nettype wire

### hdl/tccw_queue.sv
// Short command queue between the front end and the back end.
// Depends on tccw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tccw_queue
   import tccw_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   output logic         push_ready,
   input  wire cmd_type push_cmd,
   output logic         pop_valid,
   input  wire logic    pop_ready,
   output cmd_type      pop_cmd
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed word
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

### hdl/tccw_back.sv
// Back end: screen memory, cursor, scroll and clear sweeps, result register.
// Depends on tccw_pkg; takes commands from tccw_queue.
`timescale 1ns / 1ps
`default_nettype none

module tccw_back
   import tccw_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   output logic                   cmd_ready,
   input  wire cmd_type           cmd,
   input  wire logic [ATTR_W-1:0] char_attr,
   input  wire logic [ATTR_W-1:0] blank_attr,
   output back_status_type        status,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [COL_W-1:0]       rsp_col,
   output logic [ROW_W-1:0]       rsp_row,
   output logic                   rsp_scroll,
   output logic [CHAR_W-1:0]      rsp_char,
   output logic [ATTR_W-1:0]      rsp_attr
);

   localparam int SUM_W  = CELL_W + 1;
   localparam int STEP_W = COL_W + 1;
   localparam int ROWS_W = ROW_W + 1;

   typedef enum logic [3:0] {
      S_INIT  = 4'b0001,
      S_IDLE  = 4'b0010,
      S_READ  = 4'b0100,
      S_SWEEP = 4'b1000
   } state_type;

   // Map a logical cell to its slot; rows rotate by the scroll base
   function automatic logic [CELL_W-1:0] to_phys(input logic [CELL_W-1:0] logical,
                                                 input logic [CELL_W-1:0] base);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(logical) + SUM_W'(base);
      if (sum >= SUM_W'(CELL_COUNT)) begin
         sum = sum - SUM_W'(CELL_COUNT);
      end
      return sum[CELL_W-1:0];
   endfunction

   logic [CELL_WORD_W-1:0] screen_mem [CELL_COUNT];
   logic [CELL_WORD_W-1:0] mem_rdata_ff;
   logic                   mem_we;
   logic [CELL_W-1:0]      mem_waddr, mem_raddr;
   logic [CELL_WORD_W-1:0] mem_wdata;

   state_type              fsm_ff, fsm_in;
   logic [COL_W-1:0]       col_ff, col_in;
   logic [ROW_W-1:0]       row_ff, row_in;
   logic [CELL_W-1:0]      base_ff, base_in;
   logic [CELL_W-1:0]      sweep_addr_ff, sweep_addr_in;
   logic [CELL_W-1:0]      sweep_last_ff, sweep_last_in;
   logic [CELL_WORD_W-1:0] sweep_word_ff, sweep_word_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0]       rsp_col_ff, rsp_col_in;
   logic [ROW_W-1:0]       rsp_row_ff, rsp_row_in;
   logic                   rsp_scroll_ff, rsp_scroll_in;
   logic [CHAR_W-1:0]      rsp_char_ff, rsp_char_in;
   logic [ATTR_W-1:0]      rsp_attr_ff, rsp_attr_in;

   logic [CELL_W-1:0]      cursor_lin;
   logic [SUM_W-1:0]       base_step;
   logic [CELL_W-1:0]      base_next;
   logic [STEP_W-1:0]      tab_col;
   logic [COL_W-1:0]       adv_col;
   logic                   adv_inc;
   logic [ROWS_W-1:0]      row_wide;
   logic                   scroll;
   logic [ROW_W-1:0]       adv_row;

   // Cursor address and scroll base after one more row
   assign cursor_lin = CELL_W'(row_ff) * CELL_W'(SCREEN_COLUMNS) + CELL_W'(col_ff);
   assign base_step  = SUM_W'(base_ff) + SUM_W'(SCREEN_COLUMNS);
   assign base_next  = (base_step >= SUM_W'(CELL_COUNT)) ?
                       CELL_W'(base_step - SUM_W'(CELL_COUNT)) : base_step[CELL_W-1:0];
   assign tab_col    = STEP_W'(col_ff - (col_ff % COL_W'(TAB_STOP))) + STEP_W'(TAB_STOP);
   assign mem_raddr  = to_phys(cmd.cell_addr, base_ff);

   // Cursor movement for the command at the queue head
   always_comb begin
      adv_col = col_ff;
      adv_inc = 1'b0;
      case (cmd.kind)
         CMD_PRINT: begin
            adv_inc = col_ff == LAST_COL;
            adv_col = adv_inc ? '0 : col_ff + 1'b1;
         end
         CMD_LF: begin
            adv_col = '0;
            adv_inc = 1'b1;
         end
         CMD_CR: begin
            adv_col = '0;
         end
         CMD_TAB: begin
            adv_inc = tab_col >= STEP_W'(SCREEN_COLUMNS);
            adv_col = adv_inc ? '0 : tab_col[COL_W-1:0];
         end
         default: begin
            adv_col = col_ff;
         end
      endcase
      row_wide = ROWS_W'(row_ff) + ROWS_W'(adv_inc);
      scroll   = row_wide > ROWS_W'(LAST_ROW);
      adv_row  = scroll ? LAST_ROW : row_wide[ROW_W-1:0];
   end

   // Sequencer
   always_comb begin
      fsm_in        = fsm_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      base_in       = base_ff;
      sweep_addr_in = sweep_addr_ff;
      sweep_last_in = sweep_last_ff;
      sweep_word_in = sweep_word_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_col_in    = rsp_col_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_scroll_in = rsp_scroll_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_attr_in   = rsp_attr_ff;
      mem_we        = 1'b0;
      mem_waddr     = sweep_addr_ff;
      mem_wdata     = sweep_word_ff;
      cmd_ready     = 1'b0;
      case (fsm_ff)
         S_INIT, S_SWEEP: begin
            // Write one cell a cycle over the swept range
            mem_we = 1'b1;
            if (sweep_addr_ff == sweep_last_ff) begin
               fsm_in       = S_IDLE;
               rsp_valid_in = fsm_ff == S_SWEEP;
            end else begin
               sweep_addr_in = sweep_addr_ff + 1'b1;
            end
         end
         S_READ: begin
            rsp_char_in  = mem_rdata_ff[CHAR_W-1:0];
            rsp_attr_in  = mem_rdata_ff[CHAR_W +: ATTR_W];
            rsp_valid_in = 1'b1;
            fsm_in       = S_IDLE;
         end
         S_IDLE: begin
            if (cmd_valid && !rsp_valid_ff) begin
               cmd_ready     = 1'b1;
               col_in        = adv_col;
               row_in        = adv_row;
               rsp_col_in    = adv_col;
               rsp_row_in    = adv_row;
               rsp_scroll_in = scroll;
               rsp_char_in   = '0;
               rsp_attr_in   = '0;
               if (cmd.kind == CMD_PRINT) begin
                  mem_we    = 1'b1;
                  mem_waddr = to_phys(cursor_lin, base_ff);
                  mem_wdata = {char_attr, cmd.code};
               end
               if (scroll) begin
                  // Rotate rows; old top row becomes the blank bottom row
                  base_in       = base_next;
                  sweep_addr_in = base_ff;
                  sweep_last_in = base_ff + CELL_W'(SCREEN_COLUMNS - 1);
                  sweep_word_in = {blank_attr, {CHAR_W{1'b0}}};
                  fsm_in        = S_SWEEP;
               end else if (cmd.kind == CMD_CLEAR) begin
                  base_in       = '0;
                  sweep_addr_in = '0;
                  sweep_last_in = CELL_W'(CELL_COUNT - 1);
                  sweep_word_in = '0;
                  fsm_in        = S_SWEEP;
               end else if (cmd.kind == CMD_READ && cmd.in_range) begin
                  fsm_in = S_READ;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         default: begin
            fsm_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff        <= S_INIT;
         col_ff        <= '0;
         row_ff        <= '0;
         base_ff       <= '0;
         sweep_addr_ff <= '0;
         sweep_last_ff <= CELL_W'(CELL_COUNT - 1);
         sweep_word_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         fsm_ff        <= fsm_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         base_ff       <= base_in;
         sweep_addr_ff <= sweep_addr_in;
         sweep_last_ff <= sweep_last_in;
         sweep_word_ff <= sweep_word_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_col_ff    <= rsp_col_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_scroll_ff <= rsp_scroll_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_attr_ff   <= rsp_attr_in;
   end

   // Screen memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= screen_mem[mem_raddr];
   end

   assign status.init_busy  = fsm_ff == S_INIT;
   assign status.sweep_busy = fsm_ff == S_SWEEP;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_col    = rsp_col_ff;
   assign rsp_row    = rsp_row_ff;
   assign rsp_scroll = rsp_scroll_ff;
   assign rsp_char   = rsp_char_ff;
   assign rsp_attr   = rsp_attr_ff;

endmodule

`default_nettype wire

### hdl/text_console_cursor_writer_unit.sv
// Put, CR, LF, tab and unused codes pass through the queue register and the result register;
// a read adds the registered memory read, a scroll blanks one row of 80 cells and a clear zeroes
// all 2000 cells, one cell a cycle through the single screen memory write port.
// The back end takes no request while a result waits; the two-word queue takes them while busy.
// Reset (synchronous, active high): cursor at 0,0, both attributes 7; then a clearing pass zeroes
// all 2000 cells of the screen memory while req_tready stays low (register writes are taken).
`timescale 1ns / 1ps
`default_nettype none

`include "text_console_cursor_writer_unit_assert.svh"

module text_console_cursor_writer_unit
   import tccw_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,   // char_code[7:0], cell_index[18:8]
   input  wire logic [REQ_W-1:0]       req_tuser,   // req_type[1:0]
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // cursor_column[6:0], cursor_row[11:7], did_scroll[12], cell_char[20:13], cell_attr[28:21]
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   input  wire logic                   csr_wen,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int RSP_PAD_W = RSP_TDATA_W - (COL_W + ROW_W + 1 + CHAR_W + ATTR_W);

   logic [ATTR_W-1:0] char_attr_ff, blank_attr_ff;
   back_status_type   status;
   logic              push_valid, push_ready, pop_valid, pop_ready;
   cmd_type           push_cmd, pop_cmd;
   logic [COL_W-1:0]  rsp_col;
   logic [ROW_W-1:0]  rsp_row;
   logic              rsp_scroll;
   logic [CHAR_W-1:0] rsp_char;
   logic [ATTR_W-1:0] rsp_attr;

   // Attribute registers
   always_ff @(posedge clock) begin
      if (reset) begin
         char_attr_ff  <= ATTR_RESET;
         blank_attr_ff <= ATTR_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_CHAR_ATTR:  char_attr_ff  <= csr_wdata[ATTR_W-1:0];
            CSR_BLANK_ATTR: blank_attr_ff <= csr_wdata[ATTR_W-1:0];
            default:        char_attr_ff  <= char_attr_ff;
         endcase
      end
   end

   tccw_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .status     (status),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   tccw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   tccw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (pop_valid),
      .cmd_ready  (pop_ready),
      .cmd        (pop_cmd),
      .char_attr  (char_attr_ff),
      .blank_attr (blank_attr_ff),
      .status     (status),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_col    (rsp_col),
      .rsp_row    (rsp_row),
      .rsp_scroll (rsp_scroll),
      .rsp_char   (rsp_char),
      .rsp_attr   (rsp_attr)
   );

   // Pack the result word
   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp_attr, rsp_char, rsp_scroll, rsp_row, rsp_col};

   `TCCW_ASSERT_HOLDS(a_cursor_on_screen, clock, reset, rsp_tvalid,
      (rsp_row <= LAST_ROW) && (rsp_col <= LAST_COL), "cursor left the screen")
   `TCCW_ASSERT_HOLDS(a_scroll_on_last_row, clock, reset, rsp_tvalid && rsp_scroll,
      rsp_row == LAST_ROW, "scroll reported off the last row")
   `TCCW_ASSERT_HOLDS(a_no_result_in_sweep, clock, reset, status.init_busy || status.sweep_busy,
      !rsp_tvalid, "result shown while a sweep runs")
   `TCCW_ASSERT_NEXT(a_one_result_per_word, clock, reset, rsp_tvalid && rsp_tready,
      !rsp_tvalid, "result issued right after a handshake")

endmodule

`default_nettype wire

### test/text_console_cursor_writer_checker.sv
// Checker for the text console cursor writer: watches the request, result and register ports,
// keeps its own copy of the screen, cursor and attributes, and compares every result word.
// Depends on tccw_pkg for widths, request codes, control characters and register indexes.
`timescale 1ns / 1ps

module text_console_cursor_writer_checker
   import tccw_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // char_code[7:0], cell_index[18:8]
   input  logic [REQ_W-1:0]       req_tuser,   // req_type[1:0]
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // cursor_column[6:0], cursor_row[11:7], did_scroll[12], cell_char[20:13], cell_attr[28:21]
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     mismatch_count,
   output int                     reports_in_flight,
   output int                     reports_checked,
   output int                     scrolls_seen,
   output int                     clears_seen
);

   typedef struct packed {
      logic [COL_W-1:0]  column;
      logic [ROW_W-1:0]  row;
      logic              scrolled;
      logic [CHAR_W-1:0] ch;
      logic [ATTR_W-1:0] attr;
   } cursor_report_t;

   // Shadow of the block's state
   logic [CELL_WORD_W-1:0] screen_copy [CELL_COUNT];
   int                     cursor_col;
   int                     cursor_row;
   logic [ATTR_W-1:0]      print_attr;
   logic [ATTR_W-1:0]      blank_attr;

   cursor_report_t predicted_reports [$];
   int mismatch_tally;
   int checked_tally;
   int scroll_tally;
   int clear_tally;

   // Shift every row up and blank the bottom row
   function automatic void scroll_screen_copy();
      for (int i = 0; i < CELL_COUNT; i++) begin
         if (i + SCREEN_COLUMNS < CELL_COUNT)
            screen_copy[i] = screen_copy[i + SCREEN_COLUMNS];
         else
            screen_copy[i] = {blank_attr, CHAR_W'(0)};
      end
   endfunction

   // Apply one request to the shadow state and return the report it should produce
   function automatic cursor_report_t predict_console_step(logic [REQ_W-1:0] kind,
                                                           logic [CHAR_W-1:0] code,
                                                           logic [CELL_W-1:0] cell_idx);
      cursor_report_t report;
      report = '0;
      case (kind)
         REQ_PUT: begin
            if (code == CODE_LF) begin
               cursor_col = 0;
               cursor_row++;
            end else if (code == CODE_CR) begin
               cursor_col = 0;
            end else if (code == CODE_TAB) begin
               cursor_col += TAB_STOP - (cursor_col % TAB_STOP);
               if (cursor_col >= SCREEN_COLUMNS) begin
                  cursor_col = 0;
                  cursor_row++;
               end
            end else begin
               screen_copy[cursor_row * SCREEN_COLUMNS + cursor_col] = {print_attr, code};
               cursor_col++;
               if (cursor_col >= SCREEN_COLUMNS) begin
                  cursor_col = 0;
                  cursor_row++;
               end
            end
            // Scroll once the cursor falls off the last row
            if (cursor_row > SCREEN_ROWS - 1) begin
               scroll_screen_copy();
               cursor_row      = SCREEN_ROWS - 1;
               report.scrolled = 1'b1;
               scroll_tally++;
            end
         end
         REQ_CLEAR: begin
            foreach (screen_copy[i]) screen_copy[i] = '0;
            clear_tally++;
         end
         REQ_READ: begin
            if (cell_idx < CELL_COUNT) begin
               report.ch   = screen_copy[cell_idx][CHAR_W-1:0];
               report.attr = screen_copy[cell_idx][CELL_WORD_W-1:CHAR_W];
            end
         end
         default: ;
      endcase
      report.column = COL_W'(cursor_col);
      report.row    = ROW_W'(cursor_row);
      return report;
   endfunction

   function automatic void check_field(string field_name, int want, int got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field_name, want, got);
         mismatch_tally++;
      end
   endfunction

   always @(posedge clock) begin
      cursor_report_t want;
      cursor_report_t got;
      if (reset) begin
         foreach (screen_copy[i]) screen_copy[i] = '0;
         cursor_col = 0;
         cursor_row = 0;
         print_attr = ATTR_RESET;
         blank_attr = ATTR_RESET;
         predicted_reports.delete();
         mismatch_tally = 0;
         checked_tally  = 0;
         scroll_tally   = 0;
         clear_tally    = 0;
      end else begin
         // Track register writes
         if (csr_wen) begin
            case (csr_index)
               CSR_CHAR_ATTR:  print_attr = csr_wdata;
               CSR_BLANK_ATTR: blank_attr = csr_wdata;
               default: ;
            endcase
         end
         // Compare a result word against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[6:0], rsp_tdata[11:7], rsp_tdata[12],
                   rsp_tdata[20:13], rsp_tdata[28:21]};
            if (predicted_reports.size() == 0) begin
               $display("%0t ns: result word with none expected, actual %h", $time, got);
               mismatch_tally++;
            end else begin
               want = predicted_reports.pop_front();
               check_field("cursor_column", want.column,   got.column);
               check_field("cursor_row",    want.row,      got.row);
               check_field("did_scroll",    want.scrolled, got.scrolled);
               check_field("cell_char",     want.ch,       got.ch);
               check_field("cell_attr",     want.attr,     got.attr);
               checked_tally++;
            end
         end
         // Predict the result of an accepted request word
         if (req_tvalid && req_tready)
            predicted_reports.push_back(predict_console_step(req_tuser,
                                                             req_tdata[7:0],
                                                             req_tdata[18:8]));
      end
      mismatch_count    <= mismatch_tally;
      reports_in_flight <= predicted_reports.size();
      reports_checked   <= checked_tally;
      scrolls_seen      <= scroll_tally;
      clears_seen       <= clear_tally;
   end

endmodule

### test/tb_text_console_cursor_writer_unit.sv
// Testbench top for the text console cursor writer: clock, reset, request stimulus,
// register writes, output back-pressure, watchdog and verdict.
// Depends on tccw_pkg, the block and text_console_cursor_writer_checker.
`timescale 1ns / 1ps

module tb_text_console_cursor_writer_unit;
   import tccw_pkg::*;

   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS_PER_PHASE = 275;
   localparam int HOLD_OFF_CYCLES        = 300;
   localparam int SETTLE_CYCLES          = 100;
   localparam int WATCHDOG_LIMIT         = 20000;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [REQ_W-1:0]       req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_wen;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int mismatch_count;
   int reports_in_flight;
   int reports_checked;
   int scrolls_seen;
   int clears_seen;

   int send_idle_pct;
   int recv_idle_pct;
   bit hold_off_req;
   bit hold_off_done;
   int words_sent;
   int quiet_cycles;

   text_console_cursor_writer_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   text_console_cursor_writer_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .req_tuser         (req_tuser),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .csr_wen           (csr_wen),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .mismatch_count    (mismatch_count),
      .reports_in_flight (reports_in_flight),
      .reports_checked   (reports_checked),
      .scrolls_seen      (scrolls_seen),
      .clears_seen       (clears_seen)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Drive the result side: random stalls, plus one long hold-off on request
   initial begin
      rsp_tready    = 1'b0;
      hold_off_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req && !hold_off_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_done = 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Abort when no word moves on either side for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no word accepted for %0d cycles", WATCHDOG_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Offer one request word, with random idle cycles ahead of it, and hold until taken
   task automatic send_word(input logic [REQ_W-1:0] kind, input logic [CHAR_W-1:0] code,
                            input logic [CELL_W-1:0] cell_idx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= REQ_TDATA_W'({cell_idx, code});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   // Drop valid and wait until every predicted result word has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (reports_in_flight != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly console text with control characters, some reads, rare clears and noise
   task automatic send_random_request();
      int                pick;
      logic [CHAR_W-1:0] code;
      logic [CELL_W-1:0] anywhere;
      pick     = $urandom_range(99);
      code     = CHAR_W'($urandom_range(255));
      anywhere = CELL_W'($urandom_range(2047));
      if (pick < 62)
         send_word(REQ_PUT, code, anywhere);
      else if (pick < 72)
         send_word(REQ_PUT, CODE_LF, anywhere);
      else if (pick < 76)
         send_word(REQ_PUT, CODE_CR, anywhere);
      else if (pick < 84)
         send_word(REQ_PUT, CODE_TAB, anywhere);
      else if (pick < 95)
         send_word(REQ_READ, code, CELL_W'($urandom_range(CELL_COUNT - 1)));
      else if (pick < 97)
         send_word(REQ_READ, code, anywhere);
      else if (pick < 98)
         send_word(REQ_CLEAR, code, anywhere);
      else
         send_word(REQ_UNUSED, code, anywhere);
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = REQ_PUT;
      csr_wen       = 1'b0;
      csr_index     = CSR_CHAR_ATTR;
      csr_wdata     = '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_off_req  = 1'b0;
      words_sent    = 0;
      quiet_cycles  = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: blank read, byte extremes, control characters, tab wrap, reads at the edges
      send_word(REQ_READ, 8'h00, 11'd0);
      send_word(REQ_PUT, CHAR_UPPER_A, 11'd0);
      send_word(REQ_PUT, 8'hFF, 11'h7FF);
      send_word(REQ_PUT, 8'h00, 11'd0);
      send_word(REQ_READ, 8'hFF, 11'd1);
      send_word(REQ_PUT, CODE_TAB, 11'd0);
      send_word(REQ_PUT, CODE_CR, 11'd0);
      send_word(REQ_PUT, CODE_LF, 11'd0);
      // ten tabs from column 0 reach column 80 and wrap to the next row
      repeat (10) send_word(REQ_PUT, CODE_TAB, 11'd0);
      send_word(REQ_READ, 8'h00, CELL_W'(CELL_COUNT - 1));
      send_word(REQ_READ, 8'h00, CELL_W'(CELL_COUNT));
      send_word(REQ_READ, 8'h00, 11'h7FF);
      send_word(REQ_UNUSED, 8'hFF, 11'h7FF);
      send_word(REQ_CLEAR, 8'h00, 11'd0);
      send_word(REQ_READ, 8'h00, 11'd0);
      drain();

      // Random phases, each with its own attributes and idle mix
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               write_reg(CSR_CHAR_ATTR, 8'h00);
               write_reg(CSR_BLANK_ATTR, 8'hFF);
               send_idle_pct = 31;
               recv_idle_pct = 68;
            end
            1: begin
               write_reg(CSR_CHAR_ATTR, CSR_DATA_W'($urandom_range(255)));
               write_reg(CSR_BLANK_ATTR, CSR_DATA_W'($urandom_range(255)));
               send_idle_pct = 68;
               recv_idle_pct = 31;
            end
            default: begin
               write_reg(CSR_CHAR_ATTR, 8'hFF);
               write_reg(CSR_BLANK_ATTR, 8'h00);
               send_idle_pct = 0;
               recv_idle_pct = 0;
               hold_off_req  = 1'b1;
            end
         endcase
         repeat (RANDOM_ITEMS_PER_PHASE) send_random_request();
         drain();
      end

      $display("Sent %0d requests; checked %0d result words with %0d scrolls and %0d clears,",
               words_sent, reports_checked, scrolls_seen, clears_seen);
      $display("under three idle mixes, attribute extremes and one long output hold-off.");
      if (mismatch_count == 0 && reports_in_flight == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+hdl
hdl/tccw_pkg.sv
hdl/tccw_front.sv
hdl/tccw_queue.sv
hdl/tccw_back.sv
hdl/text_console_cursor_writer_unit.sv
test/text_console_cursor_writer_checker.sv
test/tb_text_console_cursor_writer_unit.sv
